FILE: design/dmng_pkg.sv
// Shared types and constants for the division magic number generator.
// No dependencies; used by dmng_div and the top level.
`default_nettype none

package dmng_pkg;

    localparam int DIVISOR_W = 32;
    localparam int SHIFT_W   = 5;
    localparam int STEP_W    = 3;

    // Bit at the top of a normalized divisor.
    localparam logic [DIVISOR_W-1:0] TOP_BIT = 32'h8000_0000;

    // Output item layout: tdata = {pad, magic_plus_one, shift_amount}.
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef logic [DIVISOR_W-1:0] word_t;
    typedef logic [SHIFT_W-1:0]   shift_t;

endpackage

`default_nettype wire

FILE: design/dmng_div.sv
// Radix-2 restoring divider: {rem_init, 32'b0} / den, one quotient bit a cycle.
// Depends on dmng_pkg; rem_init must be below den.
`default_nettype none

module dmng_div (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  start,
    input  dmng_pkg::word_t      rem_init,
    input  dmng_pkg::word_t      den,
    output logic                 done,
    output dmng_pkg::word_t      quot,
    output dmng_pkg::word_t      rem
);

    logic                         run_reg;
    logic                         done_reg;
    dmng_pkg::shift_t             cnt_reg;
    dmng_pkg::word_t              rem_reg;
    dmng_pkg::word_t              quot_reg;
    dmng_pkg::word_t              den_reg;
    logic [dmng_pkg::DIVISOR_W+1:0] diff;
    logic                         borrow;

    assign diff   = {1'b0, rem_reg, 1'b0} - {2'b00, den_reg};
    assign borrow = diff[dmng_pkg::DIVISOR_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rem_reg <= rem_init;
                den_reg <= den;
            end else if (run_reg) begin
                // keep the shifted partial remainder when the trial subtract borrows
                rem_reg  <= borrow ? {rem_reg[dmng_pkg::DIVISOR_W-2:0], 1'b0}
                                   : diff[dmng_pkg::DIVISOR_W-1:0];
                quot_reg <= {quot_reg[dmng_pkg::DIVISOR_W-2:0], ~borrow};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == dmng_pkg::SHIFT_W'(dmng_pkg::DIVISOR_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: design/division_magic_number_generator_core.sv
// An item passes from input accept through the 5-step normalizer, which finds
// the shift first, then the 32-step divider in dmng_div for a general divisor;
// a power of two skips the divider and zero goes straight to the output stage.
// One item at a time: the next item is taken from the cycle after the result is loaded.
// aresetn (synchronous) empties the block and output.
`default_nettype none

module division_magic_number_generator_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] divisor
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [4:0] shift_amount, [36:5] magic_plus_one
    output logic [1:0]  m_axis_tuser    // [0] two_steps, [1] divisor_zero
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_CHK,
        ST_DIV,
        ST_FIX,
        ST_FIN
    } state_t;

    state_t                       state_reg;
    dmng_pkg::word_t              d_reg;
    dmng_pkg::word_t              norm_reg;
    dmng_pkg::shift_t             zeros_reg;
    logic [dmng_pkg::STEP_W-1:0]  step_reg;
    dmng_pkg::word_t              q_reg;
    dmng_pkg::word_t              r_reg;
    logic                         zero_reg;
    logic                         two_reg;
    logic                         inc_reg;
    logic                         m_valid_reg;
    logic [dmng_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [dmng_pkg::M_TUSER_W-1:0] m_user_reg;

    dmng_pkg::shift_t             amt;
    dmng_pkg::word_t              hi_mask;
    dmng_pkg::shift_t             k;
    dmng_pkg::word_t              e;
    logic [dmng_pkg::DIVISOR_W:0] twice;
    dmng_pkg::word_t              magic;
    dmng_pkg::word_t              magic_p1;
    logic                         div_start;
    logic                         div_done;
    dmng_pkg::word_t              div_quot;
    dmng_pkg::word_t              div_rem;
    logic                         out_free;

    assign amt      = dmng_pkg::SHIFT_W'(1) << step_reg;
    assign hi_mask  = ~(32'hFFFF_FFFF >> amt);
    assign k        = ~zeros_reg;
    assign e        = d_reg - r_reg;
    assign twice    = {1'b0, r_reg} + {1'b0, r_reg};
    assign magic    = two_reg ? {q_reg[dmng_pkg::DIVISOR_W-2:0], inc_reg} : q_reg;
    assign magic_p1 = magic + 1'b1;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign div_start = (state_reg == ST_CHK) && (norm_reg != dmng_pkg::TOP_BIT);

    dmng_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (dmng_pkg::word_t'(1) << k),
        .den      (d_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // load a new item or drop the one just taken
            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        d_reg     <= s_axis_tdata;
                        norm_reg  <= s_axis_tdata;
                        zeros_reg <= '0;
                        step_reg  <= dmng_pkg::STEP_W'(dmng_pkg::SHIFT_W - 1);
                        zero_reg  <= (s_axis_tdata == '0);
                        state_reg <= (s_axis_tdata == '0) ? ST_FIN : ST_NORM;
                    end
                end
                ST_NORM: begin
                    // shift left by 16, 8, 4, 2, 1 while the top bits are clear
                    if ((norm_reg & hi_mask) == '0) begin
                        norm_reg  <= norm_reg << amt;
                        zeros_reg <= zeros_reg | amt;
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (norm_reg == dmng_pkg::TOP_BIT) begin
                        // power of two: quotient wraps to zero, remainder is zero
                        q_reg     <= '0;
                        r_reg     <= '0;
                        state_reg <= ST_FIX;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        q_reg     <= div_quot;
                        r_reg     <= div_rem;
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    two_reg   <= (e >> k) != '0;
                    inc_reg   <= twice[dmng_pkg::DIVISOR_W] ||
                                 (twice[dmng_pkg::DIVISOR_W-1:0] >= d_reg);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        if (zero_reg) begin
                            m_data_reg <= '0;
                            m_user_reg <= 2'b10;
                        end else begin
                            m_data_reg <= {3'b000, magic_p1, k};
                            m_user_reg <= {1'b0, two_reg};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire
